FILE: hw/rtl/drc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and the mask root table of the differential composite.
package drc_pkg;

	localparam int BYTE_W    = 8;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;
	localparam int W_W       = 17;
	localparam int ROOT_W    = 32;
	localparam int T_W       = 21;
	localparam int C_W       = 38;

	localparam logic [CFG_W-1:0] GAMMA_UNITY = 12'd256;
	localparam logic [CFG_W-1:0] ILLUM_RESET = 12'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ILLUM_SCALE = 1'b0,
		REG_MASK_GAMMA  = 1'b1
	} cfg_reg_t;

	typedef logic [ROOT_W-1:0] root_tab_t [256];

	function automatic logic [ROOT_W-1:0] isqrt64(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = v;
		r = 64'd0;
		for (int i = 31; i >= 0; i--) begin
			b = 64'd1 << (2 * i);
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
		end
		return r[ROOT_W-1:0];
	endfunction

	function automatic root_tab_t build_root_tab();
		root_tab_t tab;
		logic [63:0] x;
		for (int m = 0; m < 256; m++) begin
			x = 64'(m * 257 + ((m >= 128) ? 1 : 0)) << 16;
			for (int k = 0; k < 8; k++) begin
				x = {32'd0, isqrt64(x << 32)};
			end
			tab[m] = (m > 0 && m < 255) ? x[ROOT_W-1:0] : '0;
		end
		return tab;
	endfunction

	// The 256th root of each normalised mask value, in Q0.32; entries 0 and 255 hold zero.
	localparam root_tab_t ROOT_TAB = build_root_tab();

endpackage

FILE: hw/rtl/drc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input word and the result word.
interface drc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] back_byte;
	logic [7:0] rend_byte;
	logic [7:0] bare_byte;
	logic [7:0] mask_byte;

	modport source (output valid, back_byte, rend_byte, bare_byte, mask_byte, input ready);
	modport sink (input valid, back_byte, rend_byte, bare_byte, mask_byte, output ready);
endinterface

interface drc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;

	modport source (output valid, out_byte, input ready);
	modport sink (input valid, out_byte, output ready);
endinterface

FILE: hw/rtl/differential_render_composite.sv
`timescale 1ns / 1ps
// Pipelined differential-rendering composite of one image byte per word.
//
// The block accepts one word per clock cycle while its skid entry is empty, and passes
// each word through one input stage with the mask root table, twenty-four stages of
// the mask power unit (one square or one multiply each), three composite stages and
// the output register, whose skid entry keeps input accepted while one result waits.
// Configuration must be written only while no word is in flight; it is not enforced.
module differential_render_composite
	import drc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	drc_in_if.sink               in_ch,
	drc_out_if.source            out_ch
);

	localparam int PW_STAGES = 24;

	typedef struct packed {
		logic                    use_pow;
		logic [W_W-1:0]          w_lin;
		logic [BYTE_W-1:0]       rend;
		logic signed [T_W-1:0]   t;
		logic [ROOT_W-1:0]       root;
		logic [ROOT_W-1:0]       acc;
		logic                    have;
	} pw_word_t;

	logic signed [CFG_W-1:0] illum_scale_q;
	logic [CFG_W-1:0]        mask_gamma_q;

	logic en;

	pw_word_t               pw_s [PW_STAGES+1];
	logic [PW_STAGES:0]     pw_vld_s;

	logic [24:0]            p1_s26;
	logic signed [C_W-1:0]  p2_s26;
	logic                   vld_s26;
	logic signed [C_W-1:0]  c_s27;
	logic                   vld_s27;
	logic [BYTE_W-1:0]      byte_s28;
	logic                   vld_s28;

	logic [BYTE_W-1:0]      out_q;
	logic                   out_vld_q;
	logic [BYTE_W-1:0]      skid_q;
	logic                   skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			illum_scale_q <= ILLUM_RESET;
			mask_gamma_q  <= GAMMA_UNITY;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_ILLUM_SCALE: illum_scale_q <= cfg_data;
				REG_MASK_GAMMA:  mask_gamma_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en          = !skid_vld_q;
	assign in_ch.ready = en;

	// Input stage: mask normalisation, root lookup and the illumination term.
	logic [W_W-1:0]        w_lin_c;
	logic signed [8:0]     d_c;
	logic signed [T_W-1:0] sd_c;
	logic signed [T_W-1:0] t_c;
	pw_word_t              in_word_c;

	always_comb begin
		w_lin_c = 17'({in_ch.mask_byte, 8'b0}) + 17'(in_ch.mask_byte) + 17'(in_ch.mask_byte[7]);
		d_c     = $signed({1'b0, in_ch.rend_byte}) - $signed({1'b0, in_ch.bare_byte});
		sd_c    = T_W'(illum_scale_q) * T_W'(d_c);
		t_c     = $signed({5'b0, in_ch.back_byte, 8'b0}) + sd_c;
		in_word_c.use_pow = (mask_gamma_q != GAMMA_UNITY) && (in_ch.mask_byte != 8'h00)
			&& (in_ch.mask_byte != 8'hFF);
		in_word_c.w_lin = w_lin_c;
		in_word_c.rend  = in_ch.rend_byte;
		in_word_c.t     = t_c;
		in_word_c.root  = ROOT_TAB[in_ch.mask_byte];
		in_word_c.acc   = '0;
		in_word_c.have  = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_vld_s[0] <= 1'b0;
		end else if (en) begin
			pw_vld_s[0] <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pw_s[0] <= in_word_c;
		end
	end

	// Power unit: left-to-right square and multiply over the gamma bits.
	for (genvar j = 0; j < PW_STAGES; j++) begin : g_pw
		localparam int  BIT_POS = 11 - j / 2;
		localparam bit  IS_SQ   = (j % 2) == 0;

		logic [63:0] prod;
		pw_word_t    nxt;

		always_comb begin
			nxt = pw_s[j];
			if (IS_SQ) begin
				prod = 64'(pw_s[j].acc) * 64'(pw_s[j].acc);
				if (pw_s[j].have) begin
					nxt.acc = prod[63:32];
				end
			end else begin
				prod = 64'(pw_s[j].acc) * 64'(pw_s[j].root);
				if (mask_gamma_q[BIT_POS]) begin
					nxt.acc  = pw_s[j].have ? prod[63:32] : pw_s[j].root;
					nxt.have = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pw_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				pw_vld_s[j+1] <= pw_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pw_s[j+1] <= nxt;
			end
		end
	end

	// Composite stages: weight selection and products, sum, clamp.
	logic [W_W-1:0] w_c;
	logic [W_W-1:0] wc_c;

	always_comb begin
		if (!pw_s[PW_STAGES].use_pow) begin
			w_c = pw_s[PW_STAGES].w_lin;
		end else if (pw_s[PW_STAGES].have) begin
			w_c = {1'b0, pw_s[PW_STAGES].acc[31:16]};
		end else begin
			w_c = 17'h10000;
		end
		wc_c = 17'h10000 - w_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s26 <= 1'b0;
			vld_s27 <= 1'b0;
			vld_s28 <= 1'b0;
		end else if (en) begin
			vld_s26 <= pw_vld_s[PW_STAGES];
			vld_s27 <= vld_s26;
			vld_s28 <= vld_s27;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s26 <= 25'(w_c) * 25'(pw_s[PW_STAGES].rend);
			p2_s26 <= C_W'($signed({1'b0, wc_c})) * C_W'(pw_s[PW_STAGES].t);
			c_s27  <= $signed({5'b0, p1_s26, 8'b0}) + p2_s26;
			if (c_s27[C_W-1]) begin
				byte_s28 <= 8'h00;
			end else if ((|c_s27[36:32]) || (&c_s27[31:24])) begin
				byte_s28 <= 8'hFF;
			end else begin
				byte_s28 <= c_s27[31:24];
			end
		end
	end

	// Output register with a skid entry behind it.
	logic push;
	logic pop;

	assign push = en && vld_s28;
	assign pop  = out_vld_q && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else if (!push) begin
				out_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_vld_q) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= byte_s28;
			end
		end else if (push) begin
			if (!out_vld_q) begin
				out_q <= byte_s28;
			end else begin
				skid_q <= byte_s28;
			end
		end
	end

	assign out_ch.valid    = out_vld_q;
	assign out_ch.out_byte = out_q;

endmodule

FILE: hw/rtl/drc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the differential composite and their binding to the top level.
module drc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("A stalled result word was withdrawn.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte))
		else $error("A stalled result word changed.");

	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("Input was refused with no result word waiting.");

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("Input ready fell without a stalled result word.");

endmodule

bind differential_render_composite drc_checker u_drc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte)
);
